// File: hdl/serial_frame_receiver_macros.svh
// serial_frame_receiver_macros.svh: assertion macros for the frame receiver
// used by the datapath; expects clk and rst_n in the including scope
`ifndef SERIAL_FRAME_RECEIVER_MACROS_SVH
`define SERIAL_FRAME_RECEIVER_MACROS_SVH
`ifndef ASSERT_OFF
`define SFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SFR_ASSERT_SAME(lbl, ante, cons, msg)
`define SFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/sfr_pkg.sv
// sfr_pkg: types and constants shared by the frame receiver
// no dependencies
package sfr_pkg;

  localparam logic [7:0] START_MARK = 8'hAA;
  localparam logic [7:0] END_MARK = 8'h55;
  localparam int unsigned FRAME_OVERHEAD = 5;
  localparam int unsigned LEN_LO_IDX = 1;
  localparam int unsigned LEN_HI_IDX = 2;
  localparam int unsigned PAYLOAD_START = 3;

  typedef enum logic [2:0] {
    STAT_PAYLOAD  = 3'd0,
    STAT_EMPTY_OK = 3'd1,
    STAT_SUM_ERR  = 3'd2,
    STAT_LEN_ERR  = 3'd3,
    STAT_OVERFLOW = 3'd4
  } sfr_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } sfr_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;
    logic emit_payload;
  } sfr_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic starts_burst;
    logic last_payload;
  } sfr_stat_t;

endpackage

// File: hdl/sfr_in_if.sv
// sfr_in_if: received byte channel, valid/ready handshake
// depends on nothing
interface sfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// File: hdl/sfr_out_if.sv
// sfr_out_if: result channel, valid/ready handshake
// depends on sfr_pkg
interface sfr_out_if import sfr_pkg::*; ;
  logic        valid;
  logic        ready;
  sfr_status_t status;
  logic [7:0]  payload_byte;
  logic        last;

  modport source (output valid, output status, output payload_byte, output last,
                  input ready);
  modport sink (input valid, input status, input payload_byte, input last,
                output ready);
endinterface

// File: hdl/sfr_datapath.sv
// sfr_datapath: fill count, frame store, length and checksum tracking, output register
// depends on sfr_pkg and serial_frame_receiver_macros.svh
`include "serial_frame_receiver_macros.svh"
module sfr_datapath import sfr_pkg::*; #(
  parameter int FRAME_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  sfr_cmd_t    cmd,
  output sfr_stat_t   stat,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output sfr_status_t out_status,
  output logic [7:0]  out_byte,
  output logic        out_last
);

  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int AW = $clog2(FRAME_BYTES);

  logic [7:0]    store_mem [FRAME_BYTES];

  logic [CW-1:0] fill_r, fill_nxt;
  logic [15:0]   len_r;
  logic [7:0]    prev_r;
  logic [7:0]    sum_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW-1:0] remain_r;
  logic [7:0]    rd_data_r;

  logic          out_valid_r;
  sfr_status_t   out_status_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          idle_byte, full, storing, closing, len_ok, sum_ok, len_zero;
  logic [CW-1:0] fill_inc;

  assign idle_byte = (fill_r == '0) && (in_byte != START_MARK);
  assign full      = (fill_r == CW'(FRAME_BYTES));
  assign fill_inc  = fill_r + CW'(1);
  assign storing   = !idle_byte && !full;
  assign closing   = storing && (in_byte == END_MARK) && (fill_inc >= CW'(FRAME_OVERHEAD));
  assign len_ok    = ({1'b0, len_r} + 17'(FRAME_OVERHEAD)) == 17'(fill_inc);
  // prev_r holds the checksum byte, sum_r the payload sum ahead of it
  assign sum_ok    = (sum_r == prev_r);
  assign len_zero  = (len_r == '0);

  assign stat.out_free     = !out_valid_r || out_ready;
  assign stat.starts_burst = closing && len_ok && sum_ok && !len_zero;
  assign stat.last_payload = (remain_r == AW'(1));

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.take_byte) begin
      if (full || closing) begin
        fill_nxt = '0;
      end else if (storing) begin
        fill_nxt = fill_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && storing) begin
      store_mem[fill_r[AW-1:0]] <= in_byte;
    end
    rd_data_r <= store_mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte && storing) begin
      prev_r <= in_byte;
      if (fill_r == '0) begin
        sum_r <= '0;
      end else if (fill_r >= CW'(PAYLOAD_START + 1)) begin
        sum_r <= sum_r + prev_r;
      end
      if (fill_r == CW'(LEN_LO_IDX)) begin
        len_r[7:0] <= in_byte;
      end
      if (fill_r == CW'(LEN_HI_IDX)) begin
        len_r[15:8] <= in_byte;
      end
    end
    if (cmd.take_byte && stat.starts_burst) begin
      rd_ptr_r <= AW'(PAYLOAD_START);
      remain_r <= len_r[AW-1:0];
    end else if (cmd.emit_payload) begin
      rd_ptr_r <= rd_ptr_r + AW'(1);
      remain_r <= remain_r - AW'(1);
    end
  end

  // single results go straight to the output register at the byte's transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_payload || (cmd.take_byte && (full || closing) &&
                                      !stat.starts_burst)) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_payload) begin
      out_status_r <= STAT_PAYLOAD;
      out_byte_r   <= rd_data_r;
      out_last_r   <= stat.last_payload;
    end else if (cmd.take_byte && (full || closing)) begin
      out_byte_r <= '0;
      out_last_r <= 1'b1;
      if (full) begin
        out_status_r <= STAT_OVERFLOW;
      end else if (!len_ok) begin
        out_status_r <= STAT_LEN_ERR;
      end else if (!sum_ok) begin
        out_status_r <= STAT_SUM_ERR;
      end else begin
        out_status_r <= STAT_EMPTY_OK;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  `SFR_ASSERT_SAME(a_fill_range, 1'b1, fill_r <= CW'(FRAME_BYTES), "fill count past store size")
  `SFR_ASSERT_SAME(a_cmd_excl, cmd.emit_payload, !cmd.take_byte, "byte taken during burst")
  `SFR_ASSERT_SAME(a_emit_remain, cmd.emit_payload, remain_r != '0, "payload emitted past length")
  `SFR_ASSERT_NEXT(a_close_clears, cmd.take_byte && (closing || full), fill_r == '0, "frame not closed")

endmodule

// File: hdl/sfr_ctrl.sv
// sfr_ctrl: controller for byte intake and payload burst
// depends on sfr_pkg
module sfr_ctrl import sfr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sfr_stat_t stat,
  output sfr_cmd_t  cmd
);

  sfr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    in_ready         = 1'b0;
    cmd.take_byte    = 1'b0;
    cmd.emit_payload = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = stat.out_free;
        cmd.take_byte = in_valid && stat.out_free;
        if (cmd.take_byte && stat.starts_burst) begin
          state_nxt = ST_READ;
        end
      end
      // waits here for the registered store read
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (stat.out_free) begin
          cmd.emit_payload = 1'b1;
          state_nxt = stat.last_payload ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/serial_frame_receiver.sv
// serial_frame_receiver: one input byte per cycle while no payload burst runs and
// the output register is free. a result (overflow, length error, checksum error,
// empty frame) is registered at the closing byte's transaction and offered the
// next cycle. a good frame's payload leaves one byte per pass through the read
// state (registered store read) and load state; intake pauses till the burst ends.
// reset clears fill count, state, output valid; the frame store needs no clearing.
module serial_frame_receiver import sfr_pkg::*; #(
  parameter int FRAME_BYTES = 64
) (
  input logic       clk,
  input logic       rst_n,
  sfr_in_if.sink    in_chan,
  sfr_out_if.source out_chan
);

  sfr_cmd_t  cmd;
  sfr_stat_t stat;

  sfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sfr_datapath #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_byte    (in_chan.rx_byte),
    .out_valid  (out_chan.valid),
    .out_ready  (out_chan.ready),
    .out_status (out_chan.status),
    .out_byte   (out_chan.payload_byte),
    .out_last   (out_chan.last)
  );

endmodule

// File: tb/sv/tb.sv
// tb: self-checking bench for serial_frame_receiver, byte stream in, result stream out
// depends on sfr_pkg, sfr_in_if, sfr_out_if and the rtl top level
module tb import sfr_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_BYTES = 64;
  localparam int MAX_LEN = FRAME_BYTES - FRAME_OVERHEAD;
  localparam int RANDOM_BYTES = 370;
  localparam int GAP_PCT = 7;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    sfr_status_t status;
    logic [7:0]  payload_byte;
    logic        last;
  } frame_result_t;

  class frame_scoreboard;
    logic [6:0]    fill;
    logic [7:0]    frame_bytes [FRAME_BYTES];
    frame_result_t pending [$];
    int            mismatches;

    function new();
      fill = '0;
      mismatches = 0;
    endfunction

    function void push_result(sfr_status_t st, logic [7:0] b, logic l);
      frame_result_t r;
      r.status = st;
      r.payload_byte = b;
      r.last = l;
      pending.push_back(r);
    endfunction

    function void judge_frame();
      logic [15:0] len;
      logic [7:0]  sum;
      int          i;
      len = {frame_bytes[LEN_HI_IDX], frame_bytes[LEN_LO_IDX]};
      sum = '0;
      if (len + FRAME_OVERHEAD != fill) begin
        push_result(STAT_LEN_ERR, 8'h00, 1'b1);
        return;
      end
      for (i = 0; i < len; i++) sum += frame_bytes[PAYLOAD_START + i];
      if (sum != frame_bytes[fill - 2]) begin
        push_result(STAT_SUM_ERR, 8'h00, 1'b1);
        return;
      end
      if (len == 0) begin
        push_result(STAT_EMPTY_OK, 8'h00, 1'b1);
        return;
      end
      for (i = 0; i < len; i++)
        push_result(STAT_PAYLOAD, frame_bytes[PAYLOAD_START + i], i == len - 1);
    endfunction

    // called once per accepted input transaction
    function void note_byte(logic [7:0] b);
      if (fill == 0 && b != START_MARK) return;
      if (fill >= FRAME_BYTES) begin
        // store full: byte dropped, even a start byte
        fill = '0;
        push_result(STAT_OVERFLOW, 8'h00, 1'b1);
        return;
      end
      frame_bytes[fill] = b;
      fill++;
      if (b == END_MARK && fill >= FRAME_OVERHEAD) begin
        judge_frame();
        fill = '0;
      end
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatches++;
    endtask

    task check_result(sfr_status_t st, logic [7:0] b, logic l);
      frame_result_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result status %0d byte %02h last %0b", st, b, l));
        return;
      end
      want = pending.pop_front();
      if (st !== want.status)
        report($sformatf("status %0d, want %0d", st, want.status));
      if (b !== want.payload_byte)
        report($sformatf("payload_byte %02h, want %02h", b, want.payload_byte));
      if (l !== want.last)
        report($sformatf("last %0b, want %0b", l, want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;

  sfr_in_if  in_chan ();
  sfr_out_if out_chan ();

  serial_frame_receiver #(.FRAME_BYTES(FRAME_BYTES)) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  frame_scoreboard sb = new();
  bit              no_gaps = 1'b0;
  int              stall_cycles = 0;
  int              frame_items = 0;
  logic [7:0]      frame_q [$];

  always #4 clk = ~clk;

  // result sink, checker and watchdog
  always @(posedge clk) begin
    out_chan.ready <= no_gaps || ($urandom_range(99) >= GAP_PCT);
    if (rst_n) begin
      if (out_chan.valid && out_chan.ready)
        sb.check_result(out_chan.status, out_chan.payload_byte, out_chan.last);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[serial_frame_receiver] ERROR");
        $finish;
      end
    end
  end

  // entered and left right after a rising edge
  task automatic send_byte(input logic [7:0] b);
    if (!no_gaps)
      while ($urandom_range(99) < GAP_PCT) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
    in_chan.valid <= 1'b1;
    in_chan.rx_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_byte(b);
    frame_items++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) begin
      send_byte(frame_q[i]);
    end
  endtask

  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == END_MARK);
    return b;
  endfunction

  function automatic int pick_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(8);
    if (roll < 97) return $urandom_range(9, MAX_LEN - 1);
    return MAX_LEN;
  endfunction

  // frame with a correct length; with any_bytes the payload may hold end bytes and the checksum is random
  task automatic build_good(input int len, input bit any_bytes);
    logic [7:0] sum;
    logic [7:0] b;
    int         i;
    frame_q = {};
    sum = '0;
    frame_q.push_back(START_MARK);
    frame_q.push_back(8'(len));
    frame_q.push_back(8'(len >> 8));
    for (i = 0; i < len; i++) begin
      b = any_bytes ? 8'($urandom_range(255)) : data_byte();
      frame_q.push_back(b);
      sum += b;
    end
    // a checksum equal to the end byte would close the frame early
    if (!any_bytes && len > 0)
      while (sum == END_MARK) begin
        sum -= frame_q[frame_q.size() - 1];
        b = data_byte();
        frame_q[frame_q.size() - 1] = b;
        sum += b;
      end
    frame_q.push_back(any_bytes ? 8'($urandom_range(255)) : sum);
    frame_q.push_back(END_MARK);
  endtask

  task automatic build_overflow(input logic [7:0] extra);
    frame_q = {START_MARK};
    repeat (FRAME_BYTES - 1) frame_q.push_back(data_byte());
    frame_q.push_back(extra);
  endtask

  initial begin
    logic [7:0] b;
    int         roll;
    int         len;
    in_chan.valid <= 1'b0;
    in_chan.rx_byte <= 8'h00;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // idle bytes, empty frame, one-byte frame, bad checksum,
    // end byte as a length byte
    frame_q = {8'h00, 8'hFF, END_MARK,
               START_MARK, 8'h00, 8'h00, 8'h00, END_MARK,
               START_MARK, 8'h01, 8'h00, 8'hFF, 8'hFF, END_MARK,
               START_MARK, 8'h02, 8'h00, 8'h00, 8'h01, 8'h00, END_MARK,
               START_MARK, 8'h00, END_MARK, 8'h00, END_MARK};
    send_frame();
    // full store, the dropped byte is a start byte
    build_overflow(START_MARK);
    send_frame();

    while (frame_items < RANDOM_BYTES) begin
      no_gaps = (frame_items >= 150 && frame_items < 240);
      if ($urandom_range(99) < 30)
        repeat ($urandom_range(1, 3)) begin
          do b = 8'($urandom_range(255)); while (b == START_MARK);
          send_byte(b);
        end
      roll = $urandom_range(99);
      len = pick_len();
      if (roll < 70) begin
        build_good(len, 1'b0);
      end else if (roll < 78) begin
        build_good(len, 1'b0);
        frame_q[frame_q.size() - 2] ^= 8'($urandom_range(1, 255));
      end else if (roll < 86) begin
        build_good(len, 1'b0);
        if ($urandom_range(99) < 30)
          frame_q[LEN_HI_IDX] = 8'($urandom_range(1, 255));
        else
          frame_q[LEN_LO_IDX] = 8'(len + $urandom_range(1, 3));
      end else if (roll < 92) begin
        build_good(len, 1'b1);
      end else if (roll < 96) begin
        build_good(len, 1'b0);
        repeat ($urandom_range(1, 3)) void'(frame_q.pop_back());
      end else begin
        build_overflow(8'($urandom_range(255)));
      end
      send_frame();
    end
    no_gaps = 1'b0;
    in_chan.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("[serial_frame_receiver] OK");
    else
      $display("[serial_frame_receiver] ERROR");
    $finish;
  end
endmodule
